### hw/rtl/prc_pkg.sv
// Shared types and constants of the partition range checker.
// Used by prc_ctrl, prc_dp and the top level; depends on nothing else.
`default_nettype none

package prc_pkg;

    localparam int unsigned LBA_W   = 64;
    localparam int unsigned NUM_W   = 8;
    localparam int unsigned TYPE_W  = 8;
    localparam int unsigned VERD_W  = 3;

    // stream payload widths, tdata widths padded to whole bytes
    localparam int unsigned S_TDATA_W = 152;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [VERD_W-1:0] V_ACCEPTED = 3'd0;
    localparam logic [VERD_W-1:0] V_EMPTY    = 3'd1;
    localparam logic [VERD_W-1:0] V_EXTENDED = 3'd2;
    localparam logic [VERD_W-1:0] V_BACKWARD = 3'd3;
    localparam logic [VERD_W-1:0] V_ZERO     = 3'd4;
    localparam logic [VERD_W-1:0] V_PAST_END = 3'd5;
    localparam logic [VERD_W-1:0] V_OVERLAP  = 3'd6;
    localparam logic [VERD_W-1:0] V_FULL     = 3'd7;

    localparam logic [TYPE_W-1:0] MBR_UNUSED   = 8'h00;
    localparam logic [TYPE_W-1:0] MBR_EXT_CHS  = 8'h05;
    localparam logic [TYPE_W-1:0] MBR_EXT_LBA  = 8'h0F;
    localparam logic [TYPE_W-1:0] MBR_EXT_LNX  = 8'h85;

    localparam logic MODE_GPT = 1'b0;

    typedef struct packed {
        logic load;    // item accepted: latch fields
        logic pre1;    // form range, early verdicts
        logic pre2;    // zero length and disk bound checks
        logic scan;    // advance table scan
        logic finish;  // commit verdict to output register
    } t_cmd;

    typedef struct packed {
        logic fail;       // verdict settled before the scan
        logic hit;        // overlap found
        logic scan_done;  // all stored ranges compared
        logic out_free;   // output register can take a result
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/prc_ctrl.sv
// Controller of the partition range checker: sequences one item through
// range forming, bound checks, table scan and commit. Uses prc_pkg.
`default_nettype none

module prc_ctrl
    import prc_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRE1   = 3'd1;
    localparam logic [2:0] S_PRE2   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PRE1;
                end
            end
            S_PRE1: begin
                o_cmd.pre1 = 1'b1;
                n_state    = S_PRE2;
            end
            S_PRE2: begin
                o_cmd.pre2 = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.fail || i_status.hit || i_status.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the previous result has been taken
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // take no item while reset is held
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

endmodule

`default_nettype wire

### hw/rtl/prc_dp.sv
// Datapath of the partition range checker: entry registers, disk bound
// arithmetic, the accepted range memory and the output register. Uses prc_pkg.
`default_nettype none

module prc_dp
    import prc_pkg::*;
#(
    parameter int unsigned MAX_RANGES = 128
)
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  wire [LBA_W-1:0]      i_cfg_data,
    input  wire [S_TDATA_W-1:0]  i_in_data,
    input  wire [S_TUSER_W-1:0]  i_in_user,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output logic [M_TDATA_W-1:0] o_out_data,
    input  t_cmd                 i_cmd,
    output t_status              o_status
);

    localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int unsigned CW = $clog2(MAX_RANGES + 1);

    logic [LBA_W-1:0] mem_first [MAX_RANGES];
    logic [LBA_W-1:0] mem_last  [MAX_RANGES];

    logic [LBA_W-1:0]  r_disk;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic              r_rd_valid;
    logic              r_hit;
    logic              r_out_valid;

    logic              r_mode;
    logic [NUM_W-1:0]  r_entry;
    logic              r_empty;
    logic [TYPE_W-1:0] r_type;
    logic [LBA_W-1:0]  r_a;
    logic [LBA_W-1:0]  r_b;
    logic [LBA_W-1:0]  r_first;
    logic [LBA_W-1:0]  r_last;
    logic [LBA_W-1:0]  r_len;
    logic [LBA_W-1:0]  r_rem;
    logic              r_ge;
    logic              r_early;
    logic [VERD_W-1:0] r_verdict;
    logic              r_fail;
    logic [LBA_W-1:0]  r_rd_first;
    logic [LBA_W-1:0]  r_rd_last;
    logic [M_TDATA_W-1:0] r_out_data;

    logic [LBA_W-1:0]  n_first;
    logic              n_early;
    logic [VERD_W-1:0] n_early_v;
    logic              n_zero;
    logic              n_past;
    logic              n_overlap;
    logic              n_full;
    logic              n_accept;
    logic [VERD_W-1:0] n_verdict;
    logic [CW-1:0]     n_count;
    logic              n_read;

    // range start as used by the checks: MBR keeps the low 32 bits
    assign n_first = (r_mode == MODE_GPT) ? r_a : {32'd0, r_a[31:0]};

    always_comb begin
        n_early   = 1'b0;
        n_early_v = V_ACCEPTED;
        if (r_mode == MODE_GPT) begin
            if (r_empty) begin
                n_early   = 1'b1;
                n_early_v = V_EMPTY;
            end else if (r_b < r_a) begin
                n_early   = 1'b1;
                n_early_v = V_BACKWARD;
            end
        end else begin
            if (r_type == MBR_UNUSED) begin
                n_early   = 1'b1;
                n_early_v = V_EMPTY;
            end else if (r_type == MBR_EXT_CHS || r_type == MBR_EXT_LBA ||
                         r_type == MBR_EXT_LNX) begin
                n_early   = 1'b1;
                n_early_v = V_EXTENDED;
            end
        end
    end

    assign n_zero    = (r_len == '0);
    assign n_past    = r_ge || (r_len > r_rem);
    assign n_read    = i_cmd.scan && (r_idx != r_count);
    assign n_overlap = r_rd_valid && (r_first <= r_rd_last) && (r_last >= r_rd_first);
    assign n_full    = (r_count == CW'(MAX_RANGES));
    assign n_accept  = !r_fail && !r_hit && !n_full;

    always_comb begin
        if (r_fail) begin
            n_verdict = r_verdict;
        end else if (r_hit) begin
            n_verdict = V_OVERLAP;
        end else if (n_full) begin
            n_verdict = V_FULL;
        end else begin
            n_verdict = V_ACCEPTED;
        end
    end

    assign n_count = n_accept ? (r_count + CW'(1)) : r_count;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_disk <= i_cfg_data;
            end
            if (i_cmd.load && i_in_user[1]) begin
                r_count <= '0;
            end else if (i_cmd.finish) begin
                r_count <= n_count;
            end
            if (i_cmd.pre2) begin
                r_idx      <= '0;
                r_rd_valid <= 1'b0;
                r_hit      <= 1'b0;
            end else begin
                if (n_read) begin
                    r_idx <= r_idx + CW'(1);
                end
                r_rd_valid <= n_read;
                if (i_cmd.scan && n_overlap) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_in_user[0];
            r_entry <= i_in_data[7:0];
            r_empty <= i_in_data[8];
            r_type  <= i_in_data[16:9];
            r_a     <= i_in_data[80:17];
            r_b     <= i_in_data[144:81];
        end
        if (i_cmd.pre1) begin
            r_first <= n_first;
            r_last  <= r_b;
            r_len   <= (r_mode == MODE_GPT) ? (r_b - r_a + LBA_W'(1)) : {32'd0, r_b[31:0]};
            r_ge    <= (n_first >= r_disk);
            r_rem   <= r_disk - n_first;
            r_early <= n_early;
            r_verdict <= n_early_v;
        end
        if (i_cmd.pre2) begin
            if (r_mode != MODE_GPT) begin
                r_last <= r_first + r_len - LBA_W'(1);
            end
            if (!r_early) begin
                if (n_zero) begin
                    r_verdict <= V_ZERO;
                end else if (n_past) begin
                    r_verdict <= V_PAST_END;
                end
            end
            r_fail <= r_early || n_zero || n_past;
        end
        if (i_cmd.finish) begin
            r_out_data <= {5'd0, NUM_W'(n_count), r_entry, n_verdict};
        end
    end

    // accepted range table
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && n_accept) begin
            mem_first[r_count[AW-1:0]] <= r_first;
            mem_last[r_count[AW-1:0]]  <= r_last;
        end
        if (n_read) begin
            r_rd_first <= mem_first[r_idx[AW-1:0]];
            r_rd_last  <= mem_last[r_idx[AW-1:0]];
        end
    end

    assign o_status.fail      = r_fail;
    assign o_status.hit       = r_hit;
    assign o_status.scan_done = (r_idx == r_count) && !r_rd_valid;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### hw/rtl/partition_range_checker.sv
// Top level of the partition range checker: joins prc_ctrl and prc_dp.
// Uses prc_pkg.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata entry, tuser mode/new_disk
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata verdict, number, count
//  cfg      | in        | i_cfg_valid / o_cfg_ready     | i_cfg_data disk_sectors
//
// Each item passes range forming, bound checks, table scan and commit; the scan
// ends at once when a verdict is settled before it, and early on an overlap;
// one stored range is read a cycle.
// One item is in work at a time; the next is accepted once the result sits in
// the output register. Reset is synchronous and active low; it empties the
// table and clears disk_sectors. A stalled output holds the next result back.
`default_nettype none

module partition_range_checker
    import prc_pkg::*;
#(
    parameter int unsigned MAX_RANGES = 128
)
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [LBA_W-1:0]      i_cfg_data,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] entry_number, [8] entry_empty, [16:9] mbr_type,
    // [80:17] first_lba, [144:81] second_value, [151:145] zero
    input  wire [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode, [1] new_disk
    input  wire [S_TUSER_W-1:0]  s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // [2:0] verdict, [10:3] partition_number, [18:11] accepted_count, [23:19] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = i_rst_n;

    prc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    prc_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire

### hw/rtl/prc_checker.sv
// Port-level checks for partition_range_checker, attached by bind.
// Uses prc_pkg for payload widths.
`default_nettype none

module prc_checker
    import prc_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 s_axis_tvalid,
    input wire                 s_axis_tready,
    input wire                 m_axis_tvalid,
    input wire                 m_axis_tready,
    input wire [M_TDATA_W-1:0] m_axis_tdata
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // items accepted whose result has not been taken yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more items outstanding than the block can hold");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 2'd0)
        else $error("result shown with no item outstanding");

endmodule

bind partition_range_checker prc_checker u_prc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
